### design/assert_macros.svh
// Assertion macros shared by the drive mixer design files.
// Clock and active-low reset are passed in by the caller; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Base form: property checked on every rising edge outside reset.
`define ASSERT_AR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `ASSERT_AR(lbl, clk, rstn, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `ASSERT_AR(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

### design/ddm_pkg.sv
// Shared types and constants of the skid-steer drive mixer with odometry.
// No dependencies; imported by the controller, the datapath and the top level.
package ddm_pkg;

  // Operation codes carried on the input stream
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET       = 3'd1,
    OP_ARCADE    = 3'd2,
    OP_COAST     = 3'd3,
    OP_BRAKE     = 3'd4,
    OP_ENABLE    = 3'd5,
    OP_DISABLE   = 3'd6,
    OP_ODO_RESET = 3'd7
  } op_e;

  // Motor action reported with each result
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DRIVE = 2'd1,
    ACT_COAST = 2'd2,
    ACT_BRAKE = 2'd3
  } act_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SPEED_LIMIT  = 3'd0,
    REG_TRIM_LEFT    = 3'd1,
    REG_TRIM_RIGHT   = 3'd2,
    REG_POLARITY     = 3'd3,
    REG_PWM_FS       = 3'd4,
    REG_DIST_GAIN    = 3'd5,
    REG_HEAD_GAIN    = 3'd6
  } reg_idx_e;

  // Operand select of the shared multiplier
  typedef enum logic [2:0] {
    MS_NONE  = 3'd0,
    MS_DIST  = 3'd1,
    MS_HEAD  = 3'd2,
    MS_SCALE = 3'd3,
    MS_RECIP = 3'd4,
    MS_TRIM  = 3'd5
  } mul_sel_e;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 232;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Datapath widths: wheel sums are held sign-extended to fit the widest count
  localparam int unsigned WIDE_W    = 34;
  localparam int unsigned MUL_B_W   = 33;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned PULSE_W   = 32;
  localparam int unsigned COUNT_IN_W = 32;

  // Divide by 100 as multiply by ceil(2^29/100), exact for operands below 2^22
  localparam int unsigned DIV_SHIFT = 29;
  localparam int unsigned DIV_IN_W  = 22;
  localparam logic [22:0] DIV100_RECIP = 23'd5368710;
  localparam int unsigned Q1_W = 15;
  localparam int unsigned Q2_W = 17;

  localparam logic [6:0]  PCT_MAX  = 7'd100;
  localparam logic [14:0] DUTY_MAX = 15'h7FFF;

  // Register reset values
  localparam logic [6:0]  RST_SPEED_LIMIT = 7'd100;
  localparam logic [6:0]  RST_TRIM        = 7'd100;
  localparam logic [3:0]  RST_POLARITY    = 4'd0;
  localparam logic [14:0] RST_PWM_FS      = 15'd1000;
  localparam logic [31:0] RST_GAIN        = 32'd0;

  typedef struct packed {
    logic [6:0]  speed_limit;
    logic [6:0]  trim_left;
    logic [6:0]  trim_right;
    logic [3:0]  polarity;
    logic [14:0] pwm_fs;
    logic [31:0] dist_gain;
    logic [31:0] head_gain;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     apply;
    mul_sel_e mul_sel;
    logic     side;
    logic     acc_pulse;
    logic     acc_dist;
    logic     acc_head;
    logic     store_duty;
    logic     store_side;
    logic     set_drive;
    logic     emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic primed;
    logic drive_req;
  } sts_t;

  // One result item
  typedef struct packed {
    logic signed [15:0] duty_a;
    logic signed [15:0] duty_b;
    logic signed [15:0] duty_c;
    logic signed [15:0] duty_d;
    act_e               action;
    logic               enabled;
    logic [31:0]        pulses_left;
    logic [31:0]        pulses_right;
    logic [47:0]        distance;
    logic [47:0]        heading;
  } res_t;

endpackage

### design/ddm_ctrl.sv
// Sequencer of the drive mixer: steps one operation through the datapath.
// Depends on ddm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ddm_ctrl import ddm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  input  logic out_free_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPLY,
    ST_MUL_D,
    ST_MUL_H,
    ST_ACC_H,
    ST_L_SCALE,
    ST_L_DIV1,
    ST_L_TRIM,
    ST_L_DIV2,
    ST_R_SCALE,
    ST_R_DIV1,
    ST_R_TRIM,
    ST_R_DIV2,
    ST_R_STORE,
    ST_DONE
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          if (sts_i.op == OP_TICK && sts_i.primed) state_q <= ST_MUL_D;
          else if (sts_i.drive_req)                state_q <= ST_L_SCALE;
          else                                     state_q <= ST_DONE;
        end
        ST_MUL_D:   state_q <= ST_MUL_H;
        ST_MUL_H:   state_q <= ST_ACC_H;
        ST_ACC_H: begin
          state_q <= sts_i.drive_req ? ST_L_SCALE : ST_DONE;
        end
        ST_L_SCALE: state_q <= ST_L_DIV1;
        ST_L_DIV1:  state_q <= ST_L_TRIM;
        ST_L_TRIM:  state_q <= ST_L_DIV2;
        ST_L_DIV2:  state_q <= ST_R_SCALE;
        ST_R_SCALE: state_q <= ST_R_DIV1;
        ST_R_DIV1:  state_q <= ST_R_TRIM;
        ST_R_TRIM:  state_q <= ST_R_DIV2;
        ST_R_DIV2:  state_q <= ST_R_STORE;
        ST_R_STORE: state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free_i) state_q <= ST_IDLE;
        end
        default:    state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = MS_NONE;
    case (state_q)
      ST_IDLE:    cmd_o.load = in_valid_i;
      ST_APPLY:   cmd_o.apply = 1'b1;
      ST_MUL_D: begin
        cmd_o.mul_sel   = MS_DIST;
        cmd_o.acc_pulse = 1'b1;
      end
      ST_MUL_H: begin
        cmd_o.mul_sel  = MS_HEAD;
        cmd_o.acc_dist = 1'b1;
      end
      ST_ACC_H:   cmd_o.acc_head = 1'b1;
      ST_L_SCALE: cmd_o.mul_sel = MS_SCALE;
      ST_L_DIV1:  cmd_o.mul_sel = MS_RECIP;
      ST_L_TRIM:  cmd_o.mul_sel = MS_TRIM;
      ST_L_DIV2:  cmd_o.mul_sel = MS_RECIP;
      ST_R_SCALE: begin
        cmd_o.mul_sel    = MS_SCALE;
        cmd_o.side       = 1'b1;
        cmd_o.store_duty = 1'b1;   // left result leaves the multiplier here
      end
      ST_R_DIV1:  cmd_o.mul_sel = MS_RECIP;
      ST_R_TRIM: begin
        cmd_o.mul_sel = MS_TRIM;
        cmd_o.side    = 1'b1;
      end
      ST_R_DIV2:  cmd_o.mul_sel = MS_RECIP;
      ST_R_STORE: begin
        cmd_o.store_duty = 1'b1;
        cmd_o.store_side = 1'b1;
        cmd_o.set_drive  = 1'b1;
      end
      ST_DONE:    cmd_o.emit = out_free_i;
      default:    cmd_o = '0;
    endcase
  end

  `ASSERT_IMPL(a_emit_slot_free, clk_i, rst_ni, cmd_o.emit, out_free_i, "result emitted into a full output slot")
  `ASSERT_NEXT(a_load_to_apply, clk_i, rst_ni, cmd_o.load, state_q == ST_APPLY, "accepted item not applied next cycle")

endmodule

### design/ddm_datapath.sv
// Datapath of the drive mixer: operation state, odometry totals, shared multiplier.
// Depends on ddm_pkg and assert_macros.svh; sequenced by ddm_ctrl.
`include "assert_macros.svh"

module ddm_datapath import ddm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  cmd_t                         cmd_i,
  input  op_e                          in_op_i,
  input  logic signed [15:0]           in_left_i,
  input  logic signed [15:0]           in_right_i,
  input  logic [3:0][COUNT_IN_W-1:0]   in_count_i,
  output sts_t                         sts_o,
  output res_t                         res_o
);

  // Captured item
  op_e                          op_q;
  logic signed [15:0]           a_q, b_q;
  logic [3:0][COUNT_BITS-1:0]   cnt_q;

  // Architectural state
  logic                         en_q, primed_q;
  logic signed [15:0]           cmd_l_q, cmd_r_q;
  logic [3:0][COUNT_BITS-1:0]   prev_q;
  logic [PULSE_W-1:0]           pl_q, pr_q;
  logic [ACC_W-1:0]             dist_q, head_q;
  act_e                         act_q;

  // Work registers
  logic signed [WIDE_W-1:0]     sl_q, sr_q;
  logic [ACC_W-1:0]             prod_q;
  logic signed [15:0]           duty_l_q, duty_r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_op_i;
      a_q  <= in_left_i;
      b_q  <= in_right_i;
      for (int k = 0; k < 4; k++) begin
        cnt_q[k] <= in_count_i[k][COUNT_BITS-1:0];
      end
    end
  end

  // Count deltas wrap at COUNT_BITS and are read as signed
  logic signed [COUNT_BITS-1:0] delta [4];
  logic signed [WIDE_W-1:0]     sl_d, sr_d;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      delta[k] = $signed(cnt_q[k] - prev_q[k]);
    end
    sl_d = WIDE_W'(delta[0]) + WIDE_W'(delta[1]);
    sr_d = WIDE_W'(delta[2]) + WIDE_W'(delta[3]);
  end

  // Arcade mix, computed wide then clamped to the speed limit
  logic signed [16:0] sum_ab, dif_ab, lim_pos, lim_neg, arc_l, arc_r;

  always_comb begin
    sum_ab  = 17'(a_q) + 17'(b_q);
    dif_ab  = 17'(a_q) - 17'(b_q);
    lim_pos = $signed({10'b0, cfg_i.speed_limit});
    lim_neg = -lim_pos;
    if (sum_ab > lim_pos)      arc_l = lim_pos;
    else if (sum_ab < lim_neg) arc_l = lim_neg;
    else                       arc_l = sum_ab;
    if (dif_ab > lim_pos)      arc_r = lim_pos;
    else if (dif_ab < lim_neg) arc_r = lim_neg;
    else                       arc_r = dif_ab;
  end

  // Side pulses: half the sum, rounded half away from zero
  logic signed [WIDE_W-1:0] rnd_sum_l, rnd_sum_r, rnd_l, rnd_r;

  always_comb begin
    rnd_sum_l = sl_q + $signed({{(WIDE_W-1){1'b0}}, ~sl_q[WIDE_W-1]});
    rnd_sum_r = sr_q + $signed({{(WIDE_W-1){1'b0}}, ~sr_q[WIDE_W-1]});
    rnd_l     = rnd_sum_l >>> 1;
    rnd_r     = rnd_sum_r >>> 1;
  end

  // Percent magnitude of the selected side after both clamps
  logic signed [15:0] cmd_side;
  logic signed [16:0] cmd_ext;
  logic [16:0]        cmd_abs;
  logic [6:0]         lim_eff, side_mag;

  always_comb begin
    cmd_side = cmd_i.side ? cmd_r_q : cmd_l_q;
    cmd_ext  = 17'(cmd_side);
    cmd_abs  = cmd_side[15] ? -cmd_ext : cmd_ext;
    lim_eff  = (cfg_i.speed_limit > PCT_MAX) ? PCT_MAX : cfg_i.speed_limit;
    side_mag = (cmd_abs > {10'b0, lim_eff}) ? lim_eff : cmd_abs[6:0];
  end

  // Shared multiplier
  logic signed [WIDE_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]        mul_b;
  logic signed [WIDE_W+MUL_B_W-1:0] mul_p;

  always_comb begin
    case (cmd_i.mul_sel)
      MS_DIST: begin
        mul_a = sl_q + sr_q;
        mul_b = $signed({1'b0, cfg_i.dist_gain});
      end
      MS_HEAD: begin
        mul_a = sr_q - sl_q;
        mul_b = $signed({1'b0, cfg_i.head_gain});
      end
      MS_SCALE: begin
        mul_a = $signed(WIDE_W'(side_mag));
        mul_b = $signed(MUL_B_W'(cfg_i.pwm_fs));
      end
      MS_RECIP: begin
        mul_a = $signed(WIDE_W'(prod_q[DIV_IN_W-1:0]));
        mul_b = $signed(MUL_B_W'(DIV100_RECIP));
      end
      MS_TRIM: begin
        mul_a = $signed(WIDE_W'(prod_q[DIV_SHIFT +: Q1_W]));
        mul_b = $signed(MUL_B_W'(cmd_i.side ? cfg_i.trim_right : cfg_i.trim_left));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Duty from the second quotient: saturate, then restore the command sign
  logic [Q2_W-1:0]    q2;
  logic [14:0]        mag_sat;
  logic               store_neg;
  logic signed [15:0] duty_new;

  always_comb begin
    q2        = prod_q[DIV_SHIFT +: Q2_W];
    mag_sat   = (q2 > Q2_W'(DUTY_MAX)) ? DUTY_MAX : q2[14:0];
    store_neg = cmd_i.store_side ? cmd_r_q[15] : cmd_l_q[15];
    duty_new  = store_neg ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      sl_q <= sl_d;
      sr_q <= sr_d;
    end
    if (cmd_i.mul_sel != MS_NONE) prod_q <= mul_p[ACC_W-1:0];
    if (cmd_i.store_duty) begin
      if (cmd_i.store_side) duty_r_q <= duty_new;
      else                  duty_l_q <= duty_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      primed_q <= 1'b0;
      cmd_l_q  <= '0;
      cmd_r_q  <= '0;
      prev_q   <= '0;
      pl_q     <= '0;
      pr_q     <= '0;
      dist_q   <= '0;
      head_q   <= '0;
      act_q    <= ACT_NONE;
    end else begin
      if (cmd_i.apply) begin
        act_q <= ACT_NONE;
        case (op_q)
          OP_TICK: begin
            prev_q   <= cnt_q;
            primed_q <= 1'b1;
          end
          OP_SET: begin
            cmd_l_q <= a_q;
            cmd_r_q <= b_q;
          end
          OP_ARCADE: begin
            cmd_l_q <= $signed(arc_l[15:0]);
            cmd_r_q <= $signed(arc_r[15:0]);
          end
          OP_COAST: begin
            cmd_l_q <= '0;
            cmd_r_q <= '0;
            act_q   <= ACT_COAST;
          end
          OP_BRAKE: begin
            cmd_l_q <= '0;
            cmd_r_q <= '0;
            act_q   <= ACT_BRAKE;
          end
          OP_ENABLE:  en_q <= 1'b1;
          OP_DISABLE: begin
            en_q    <= 1'b0;
            cmd_l_q <= '0;
            cmd_r_q <= '0;
            act_q   <= ACT_COAST;
          end
          OP_ODO_RESET: begin
            primed_q <= 1'b0;
            prev_q   <= '0;
            pl_q     <= '0;
            pr_q     <= '0;
            dist_q   <= '0;
            head_q   <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.acc_pulse) begin
        pl_q <= pl_q + rnd_l[PULSE_W-1:0];
        pr_q <= pr_q + rnd_r[PULSE_W-1:0];
      end
      if (cmd_i.acc_dist)  dist_q <= dist_q + prod_q;
      if (cmd_i.acc_head)  head_q <= head_q + prod_q;
      if (cmd_i.set_drive) act_q  <= ACT_DRIVE;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.primed    = primed_q;
  assign sts_o.drive_req = en_q && (op_q == OP_SET || op_q == OP_ARCADE ||
                           (op_q == OP_TICK && (cmd_l_q != '0 || cmd_r_q != '0)));

  logic drv;
  assign drv = (act_q == ACT_DRIVE);

  always_comb begin
    res_o.duty_a       = !drv ? '0 : (cfg_i.polarity[0] ? -duty_l_q : duty_l_q);
    res_o.duty_b       = !drv ? '0 : (cfg_i.polarity[1] ? -duty_l_q : duty_l_q);
    res_o.duty_c       = !drv ? '0 : (cfg_i.polarity[2] ? -duty_r_q : duty_r_q);
    res_o.duty_d       = !drv ? '0 : (cfg_i.polarity[3] ? -duty_r_q : duty_r_q);
    res_o.action       = act_q;
    res_o.enabled      = en_q;
    res_o.pulses_left  = pl_q;
    res_o.pulses_right = pr_q;
    res_o.distance     = dist_q;
    res_o.heading      = head_q;
  end

  `ASSERT_NEXT(a_first_tick_latches, clk_i, rst_ni, cmd_i.apply && op_q == OP_TICK && !primed_q, $stable(dist_q) && $stable(head_q) && $stable(pl_q) && $stable(pr_q), "unprimed tick changed odometry totals")
  `ASSERT_NEXT(a_stop_clears_cmd, clk_i, rst_ni, cmd_i.apply && (op_q == OP_COAST || op_q == OP_BRAKE || op_q == OP_DISABLE), cmd_l_q == '0 && cmd_r_q == '0, "stop left a non-zero command")

endmodule

### design/diff_drive_mixer_odometry_core.sv
// Top level of the four-wheel skid-steer drive mixer with wheel odometry.
// Depends on ddm_pkg, ddm_ctrl and ddm_datapath.

// One input transfer carries one operation (tick, set left/right, arcade,
// coast, brake, enable, disable, odometry reset) and always yields exactly
// one result transfer holding four signed duties, the motor action, the
// enable state, the two side pulse totals and the Q24.24 distance and
// heading totals. Items are handled one at a time by a small sequencer
// around a single shared multiplier. Enable, odometry reset, the stops and
// set/arcade while disabled go from the apply step straight to the output
// register; set/arcade while enabled add two sides of four multiplier
// passes each (scale by full scale, divide by 100, trim, divide by 100); a
// tick adds the distance and heading products once the counts are primed
// and refreshes the drive while enabled with a non-zero command. The
// sequencer takes the next item as soon as the previous result sits in the
// output register, even if the sink has not taken it yet; a result waits
// there until the sink is ready. Configuration writes are always accepted
// and must only be issued while no item is in flight. COUNT_BITS selects
// how many low encoder bits are used; deltas wrap at that width. Divisions
// by 100 truncate toward zero.

module diff_drive_mixer_odometry_core import ddm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // left_or_throttle[15:0], right_or_turn[31:16], count_a[63:32],
  // count_b[95:64], count_c[127:96], count_d[159:128]
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // operation[2:0]
  input  logic [IN_USER_W-1:0]   s_axis_tuser,

  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // duty_a[15:0], duty_b[31:16], duty_c[47:32], duty_d[63:48],
  // drive_enabled[64], pulses_left[96:65], pulses_right[128:97],
  // distance[176:129], heading[224:177], zero fill[231:225]
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // motor_action[1:0]
  output logic [OUT_USER_W-1:0]  m_axis_tuser,

  // Configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit <= RST_SPEED_LIMIT;
      cfg_q.trim_left   <= RST_TRIM;
      cfg_q.trim_right  <= RST_TRIM;
      cfg_q.polarity    <= RST_POLARITY;
      cfg_q.pwm_fs      <= RST_PWM_FS;
      cfg_q.dist_gain   <= RST_GAIN;
      cfg_q.head_gain   <= RST_GAIN;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SPEED_LIMIT: cfg_q.speed_limit <= cfg_data_i[6:0];
        REG_TRIM_LEFT:   cfg_q.trim_left   <= cfg_data_i[6:0];
        REG_TRIM_RIGHT:  cfg_q.trim_right  <= cfg_data_i[6:0];
        REG_POLARITY:    cfg_q.polarity    <= cfg_data_i[3:0];
        REG_PWM_FS:      cfg_q.pwm_fs      <= cfg_data_i[14:0];
        REG_DIST_GAIN:   cfg_q.dist_gain   <= cfg_data_i;
        REG_HEAD_GAIN:   cfg_q.head_gain   <= cfg_data_i;
        default: ;       // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and datapath
  // ---------------------------------------------------------------------
  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic out_free;

  logic [3:0][COUNT_IN_W-1:0] in_count;
  assign in_count[0] = s_axis_tdata[63:32];
  assign in_count[1] = s_axis_tdata[95:64];
  assign in_count[2] = s_axis_tdata[127:96];
  assign in_count[3] = s_axis_tdata[159:128];

  ddm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  ddm_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .in_op_i    (op_e'(s_axis_tuser)),
    .in_left_i  ($signed(s_axis_tdata[15:0])),
    .in_right_i ($signed(s_axis_tdata[31:16])),
    .in_count_i (in_count),
    .sts_o      (sts),
    .res_o      (res)
  );

  // ---------------------------------------------------------------------
  // Output register: holds one finished result so the sequencer can move
  // on to the next item while the sink stalls.
  // ---------------------------------------------------------------------
  logic out_valid_q;
  res_t out_q;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.action;
  assign m_axis_tdata  = {7'b0, out_q.heading, out_q.distance, out_q.pulses_right,
                          out_q.pulses_left, out_q.enabled, out_q.duty_d, out_q.duty_c,
                          out_q.duty_b, out_q.duty_a};

endmodule

### bench/tb_diff_drive_mixer_odometry_core.sv
// Self-checking bench for the skid-steer drive mixer with wheel odometry.
// A predictor class tracks commands, enable state and odometry totals and checks every result.
// Depends on ddm_pkg and diff_drive_mixer_odometry_core.
`timescale 1ns / 100ps

module tb_diff_drive_mixer_odometry_core import ddm_pkg::*; ();

  // Predictor of the mixer: holds its own copy of the registers and the state,
  // works out one expected result per accepted operation and checks results in order.
  class drive_odometry_tracker;
    logic [6:0]       speed_limit, trim_left, trim_right;
    logic [3:0]       polarity;
    logic [14:0]      pwm_fs;
    logic [31:0]      dist_gain, head_gain;
    bit               enabled, primed;
    int               cmd_left, cmd_right;
    logic [3:0][31:0] last_counts;
    logic [31:0]      pulse_left, pulse_right;
    logic [47:0]      dist_total, head_total;
    res_t             pending_results[$];
    int               n_items, n_checked, n_driven, n_bad;

    function new();
      speed_limit = 7'd100;
      trim_left   = 7'd100;
      trim_right  = 7'd100;
      polarity    = 4'd0;
      pwm_fs      = 15'd1000;
      dist_gain   = '0;
      head_gain   = '0;
      enabled     = 1'b0;
      cmd_left    = 0;
      cmd_right   = 0;
      clear_odometry();
      n_items = 0; n_checked = 0; n_driven = 0; n_bad = 0;
    endfunction

    function void clear_odometry();
      primed      = 1'b0;
      last_counts = '0;
      pulse_left  = '0;
      pulse_right = '0;
      dist_total  = '0;
      head_total  = '0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] val);
      case (idx)
        REG_SPEED_LIMIT: speed_limit = val[6:0];
        REG_TRIM_LEFT:   trim_left   = val[6:0];
        REG_TRIM_RIGHT:  trim_right  = val[6:0];
        REG_POLARITY:    polarity    = val[3:0];
        REG_PWM_FS:      pwm_fs      = val[14:0];
        REG_DIST_GAIN:   dist_gain   = val;
        REG_HEAD_GAIN:   head_gain   = val;
        default: ;
      endcase
    endfunction

    function int clamp_pct(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // percent -> duty: limit, +-100, full scale /100, trim /100, saturate
    function longint side_duty(int pct, logic [6:0] trim);
      longint lim, p, d;
      lim = speed_limit;
      p = pct;
      if (p > lim) p = lim;
      if (p < -lim) p = -lim;
      if (p > 100) p = 100;
      if (p < -100) p = -100;
      d = p * longint'(pwm_fs) / 100;
      d = d * longint'(trim) / 100;
      if (d > 32767) d = 32767;
      if (d < -32767) d = -32767;
      return d;
    endfunction

    function res_t drive_result();
      res_t   r;
      longint l, rr;
      r  = '0;
      l  = side_duty(cmd_left, trim_left);
      rr = side_duty(cmd_right, trim_right);
      r.duty_a = 16'(polarity[0] ? -l : l);
      r.duty_b = 16'(polarity[1] ? -l : l);
      r.duty_c = 16'(polarity[2] ? -rr : rr);
      r.duty_d = 16'(polarity[3] ? -rr : rr);
      r.action = ACT_DRIVE;
      n_driven++;
      return r;
    endfunction

    function longint round_half(longint s);
      if (s >= 0) return (s + 1) / 2;
      return -((-s + 1) / 2);
    endfunction

    function void odometry_tick(logic [3:0][31:0] cnt);
      longint      delta [4];
      longint      sl, sr;
      logic [31:0] diff;
      // first tick after reset only latches the counts
      if (!primed) begin
        last_counts = cnt;
        primed = 1'b1;
        return;
      end
      for (int k = 0; k < 4; k++) begin
        diff = cnt[k] - last_counts[k];
        delta[k] = longint'($signed(diff));
      end
      last_counts = cnt;
      sl = delta[0] + delta[1];
      sr = delta[2] + delta[3];
      pulse_left  += 32'(round_half(sl));
      pulse_right += 32'(round_half(sr));
      dist_total  += 48'((sl + sr) * longint'(dist_gain));
      head_total  += 48'((sr - sl) * longint'(head_gain));
    endfunction

    function void note_item(op_e op, shortint lt, shortint rt, logic [3:0][31:0] cnt);
      res_t e;
      int   lim;
      e   = '0;
      lim = speed_limit;
      case (op)
        OP_TICK: begin
          odometry_tick(cnt);
          if (enabled && (cmd_left != 0 || cmd_right != 0)) e = drive_result();
        end
        OP_SET, OP_ARCADE: begin
          if (op == OP_SET) begin
            cmd_left  = lt;
            cmd_right = rt;
          end else begin
            // mixed sums are taken wide, then limited
            cmd_left  = clamp_pct(int'(lt) + int'(rt), lim);
            cmd_right = clamp_pct(int'(lt) - int'(rt), lim);
          end
          if (enabled) e = drive_result();
        end
        OP_COAST, OP_BRAKE: begin
          cmd_left  = 0;
          cmd_right = 0;
          e.action  = (op == OP_BRAKE) ? ACT_BRAKE : ACT_COAST;
        end
        OP_ENABLE: enabled = 1'b1;
        OP_DISABLE: begin
          enabled   = 1'b0;
          cmd_left  = 0;
          cmd_right = 0;
          e.action  = ACT_COAST;
        end
        OP_ODO_RESET: clear_odometry();
        default: ;
      endcase
      e.enabled      = enabled;
      e.pulses_left  = pulse_left;
      e.pulses_right = pulse_right;
      e.distance     = dist_total;
      e.heading      = head_total;
      pending_results.push_back(e);
      n_items++;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function bit field_ok(string f, logic [47:0] exp_v, logic [47:0] act_v);
      if (exp_v === act_v) return 1'b1;
      $display("%0t: result %0d field %s mismatch: expected %h, actual %h",
               $time, n_checked, f, exp_v, act_v);
      return 1'b0;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
      res_t e;
      bit   ok;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no expectation waiting: expected none, actual tdata %h",
                 $time, d);
        n_bad++;
        return;
      end
      e  = pending_results.pop_front();
      ok = 1'b1;
      ok &= field_ok("duty_a", 48'(e.duty_a), 48'($signed(d[15:0])));
      ok &= field_ok("duty_b", 48'(e.duty_b), 48'($signed(d[31:16])));
      ok &= field_ok("duty_c", 48'(e.duty_c), 48'($signed(d[47:32])));
      ok &= field_ok("duty_d", 48'(e.duty_d), 48'($signed(d[63:48])));
      ok &= field_ok("motor_action", 48'(e.action), 48'(u));
      ok &= field_ok("drive_enabled", 48'(e.enabled), 48'(d[64]));
      ok &= field_ok("pulses_left", 48'(e.pulses_left), 48'(d[96:65]));
      ok &= field_ok("pulses_right", 48'(e.pulses_right), 48'(d[128:97]));
      ok &= field_ok("distance", e.distance, d[176:129]);
      ok &= field_ok("heading", e.heading, d[224:177]);
      if (!ok) n_bad++;
      n_checked++;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  drive_odometry_tracker tracker = new();

  // idle odds in percent on each side
  int send_idle = 0;
  int recv_idle = 0;
  int n_settings = 0;
  // running encoder counts fed to tick operations
  logic [3:0][31:0] enc = '0;

  diff_drive_mixer_odometry_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Result side: check each transfer, then pick the ready level for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_result(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  // Offer one operation and wait for its transfer. tvalid is left high on
  // return so back-to-back items keep it high unless the next one idles first.
  task automatic send_item(input op_e op, input shortint lt, input shortint rt,
                           input logic [3:0][31:0] cnt);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {cnt, rt, lt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_item(op, lt, rt, cnt);
  endtask

  // Non-tick operation; the count fields carry noise.
  task automatic send_cmd(input op_e op, input shortint lt, input shortint rt);
    send_item(op, lt, rt, {$urandom, $urandom, $urandom, $urandom});
  endtask

  task automatic tick_by(input logic [31:0] da, input logic [31:0] db,
                         input logic [31:0] dc, input logic [31:0] dd);
    enc[0] += da;
    enc[1] += db;
    enc[2] += dc;
    enc[3] += dd;
    send_item(OP_TICK, shortint'($urandom), shortint'($urandom), enc);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.write_reg(idx, val);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Register settings; the block is idle whenever this runs.
  task automatic load_setting(input int which);
    logic [6:0]  sl, tl, tr;
    logic [3:0]  pol;
    logic [14:0] fs;
    logic [31:0] dg, hg;
    case (which)
      0: begin
        sl = 7'd100; tl = 7'd100; tr = 7'd100; pol = 4'b0101; fs = 15'd1000;
        dg = 32'h0019_999A; hg = 32'h0123_4567;
      end
      1: begin
        sl = 7'd100; tl = 7'd100; tr = 7'd100; pol = 4'd0; fs = 15'd1000;
        dg = $urandom; hg = $urandom;
      end
      // low extremes
      2: begin
        sl = 7'd0; tl = 7'd0; tr = 7'd0; pol = 4'hF; fs = 15'd1;
        dg = 32'd0; hg = 32'd0;
      end
      // high extremes: limit and trims past 100, duties saturate
      3: begin
        sl = 7'd127; tl = 7'd127; tr = 7'd127; pol = 4'hF; fs = 15'h7FFF;
        dg = 32'hFFFF_FFFF; hg = 32'hFFFF_FFFF;
      end
      // zero full scale gives zero duties
      4: begin
        sl = 7'd100; tl = 7'd100; tr = 7'd100; pol = 4'hA; fs = 15'd0;
        dg = 32'h0100_0000; hg = 32'h0394_BB83;
      end
      5: begin
        sl = 7'($urandom_range(100)); tl = 7'($urandom_range(100));
        tr = 7'($urandom_range(100)); pol = 4'($urandom);
        fs = 15'($urandom_range(32767, 1)); dg = $urandom; hg = $urandom;
      end
      default: begin
        sl = 7'($urandom); tl = 7'($urandom); tr = 7'($urandom); pol = 4'($urandom);
        fs = 15'($urandom); dg = $urandom; hg = $urandom;
      end
    endcase
    write_reg(REG_SPEED_LIMIT, 32'(sl));
    write_reg(REG_TRIM_LEFT, 32'(tl));
    write_reg(REG_TRIM_RIGHT, 32'(tr));
    write_reg(REG_POLARITY, 32'(pol));
    write_reg(REG_PWM_FS, 32'(fs));
    write_reg(REG_DIST_GAIN, dg);
    write_reg(REG_HEAD_GAIN, hg);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic drive_corner_cases();
    send_cmd(OP_SET, 16'sd50, -16'sd50);           // stored while disabled
    enc = {32'hFFFF_FFFB, 32'd5, 32'h8000_0000, 32'h7FFF_FFFF};
    send_item(OP_TICK, 16'sd0, 16'sd0, enc);       // priming tick only latches
    send_cmd(OP_ENABLE, 16'sd0, 16'sd0);
    tick_by(32'd1, -32'sd1, 32'd1, 32'd0);         // counts wrap both ways
    tick_by(-32'sd3, 32'd0, 32'd3, 32'd0);         // odd sums round away from zero
    tick_by(32'd1, 32'd0, -32'sd1, 32'd0);
    send_cmd(OP_SET, 16'sh7FFF, 16'sh8000);
    send_cmd(OP_ARCADE, 16'sh7FFF, 16'sh7FFF);     // mixing taken wide
    send_cmd(OP_ARCADE, 16'sh8000, 16'sh7FFF);
    send_cmd(OP_ARCADE, 16'sd30, -16'sd20);
    send_cmd(OP_SET, 16'sd0, 16'sd0);
    tick_by(32'd7, 32'd9, 32'd2, 32'd0);           // zero commands: no refresh
    send_cmd(OP_SET, 16'sd101, -16'sd101);
    tick_by(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_cmd(OP_COAST, 16'sd0, 16'sd0);
    send_cmd(OP_BRAKE, 16'sd0, 16'sd0);
    send_cmd(OP_DISABLE, 16'sd0, 16'sd0);
    send_cmd(OP_BRAKE, 16'sd0, 16'sd0);            // stops report even when disabled
    send_cmd(OP_COAST, 16'sd0, 16'sd0);
    send_cmd(OP_SET, -16'sd100, 16'sd100);
    send_cmd(OP_ODO_RESET, 16'sd0, 16'sd0);
    tick_by(32'd100, 32'd100, 32'd100, 32'd100);   // primes again
    send_cmd(OP_ENABLE, 16'sd0, 16'sd0);
    tick_by(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_cmd(OP_ODO_RESET, 16'sd0, 16'sd0);
  endtask

  function automatic shortint rand_pct();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return shortint'(int'($urandom_range(260)) - 130);
    if (roll < 85) return shortint'($urandom);
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return -16'sd101;
      3: return -16'sd100;
      4: return 16'sd100;
      5: return 16'sd101;
      6: return -16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // Mostly realistic traffic: small encoder steps, commands near the percent
  // range, drive enabled most of the time; the rest is wide or wild values.
  task automatic send_random_item();
    int  roll;
    op_e op;
    roll = $urandom_range(99);
    if (roll < 42)      op = OP_TICK;
    else if (roll < 58) op = OP_SET;
    else if (roll < 74) op = OP_ARCADE;
    else if (roll < 83) op = OP_ENABLE;
    else if (roll < 88) op = OP_DISABLE;
    else if (roll < 92) op = OP_COAST;
    else if (roll < 96) op = OP_BRAKE;
    else                op = OP_ODO_RESET;
    if (op == OP_TICK) begin
      for (int k = 0; k < 4; k++) begin
        roll = $urandom_range(99);
        if (roll < 85)      enc[k] += 32'($urandom_range(600)) - 32'd300;
        else if (roll < 95) enc[k] += $urandom;
        else                enc[k] = $urandom;
      end
      send_item(op, rand_pct(), rand_pct(), enc);
    end else begin
      send_cmd(op, rand_pct(), rand_pct());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 29;
    recv_idle = 62;
    load_setting(0);
    drive_corner_cases();
    drain();

    // three random phases of idling: sender-heavy receiver stalls, the
    // reverse, then full throughput; two register settings each
    for (int ph = 1; ph <= 6; ph++) begin
      case ((ph - 1) / 2)
        0: begin send_idle = 29; recv_idle = 62; end
        1: begin send_idle = 62; recv_idle = 29; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      load_setting(ph);
      repeat (300) send_random_item();
      drain();
    end

    // late or extra results would show up here
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d operations under %0d register settings and three idle patterns;",
             tracker.n_items, n_settings);
    $display("%0d results checked, %0d with duties applied, %0d bad.",
             tracker.n_checked, tracker.n_driven, tracker.n_bad);
    if (tracker.n_bad == 0 && tracker.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", tracker.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
